// File: hdl/rtms_pkg.sv
// ----------------------------------------------------------------------------
// rtms_pkg: shared types and constants of the record table
// Record layout, operation and status codes, and the command and status
// groups passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package rtms_pkg;

  // Default number of table entries.
  localparam int TABLE_DEPTH = 64;

  // Reset value of the count threshold.
  localparam logic [31:0] THRESHOLD_RESET = 32'd1000;

  // Width of the packed record and of the input data bus.
  localparam int REC_W = 105;
  localparam int IN_W  = 112;

  // Operation codes.
  localparam logic [2:0] OP_APPEND = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_COUNT  = 3'd2;
  localparam logic [2:0] OP_LIST   = 3'd3;
  localparam logic [2:0] OP_MLIST  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Sources of a result beat.
  localparam logic [2:0] SRC_EMPTY = 3'd0;
  localparam logic [2:0] SRC_FULL  = 3'd1;
  localparam logic [2:0] SRC_ECHO  = 3'd2;
  localparam logic [2:0] SRC_REC   = 3'd3;
  localparam logic [2:0] SRC_COUNT = 3'd4;

  // One record; the code sits in the lowest bits.
  typedef struct packed {
    logic [3:0]  month;
    logic [4:0]  day;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] code;
  } rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       in_load;
    logic       rec_rd;
    logic       rec_rd_srt;
    logic       rec_wr;
    logic       rec_wr_in;
    logic       srt_rd;
    logic       srt_wr;
    logic       srt_wr_init;
    logic       srt_cmp;
    logic       cur_load;
    logic       cnt_clr;
    logic       cnt_acc;
    logic       out_load;
    logic [2:0] out_src;
    logic       out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       out_free;
    logic       code_match;
    logic [2:0] op;
  } sts_t;

endpackage

// File: hdl/rtms_dp.sv
// ----------------------------------------------------------------------------
// rtms_dp: record table datapath
// Record memory, sort order memory, compare and count logic, the threshold
// register and the result register.
// ----------------------------------------------------------------------------
module rtms_dp #(
  parameter int TABLE_DEPTH = rtms_pkg::TABLE_DEPTH,
  localparam int AW   = $clog2(TABLE_DEPTH),
  localparam int CntW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [31:0]         cfg_wr_data,
  input  rtms_pkg::rec_t      in_rec,
  input  logic [2:0]          in_op,
  input  rtms_pkg::cmd_t      cmd,
  input  logic [AW-1:0]       rec_rd_addr,
  input  logic [AW-1:0]       rec_wr_addr,
  input  logic [AW-1:0]       srt_rd_addr,
  input  logic [AW-1:0]       srt_wr_addr,
  output rtms_pkg::sts_t      sts,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_status,
  output rtms_pkg::rec_t      out_rec,
  output logic [CntW-1:0]     out_cnt,
  output logic                out_last
);

  rtms_pkg::rec_t rec_mem [TABLE_DEPTH];
  logic [AW-1:0]  srt_idx_mem [TABLE_DEPTH];
  logic [3:0]     srt_mon_mem [TABLE_DEPTH];

  rtms_pkg::rec_t inp;
  logic [2:0]     op;
  rtms_pkg::rec_t rec_rd;
  logic [AW-1:0]  srt_idx_rd;
  logic [3:0]     srt_mon_rd;
  logic [AW-1:0]  cur_idx;
  logic [3:0]     cur_mon;
  logic [CntW-1:0] cnt;
  logic [31:0]    thr;

  logic           swap;
  logic           srt_we;
  logic [AW-1:0]  srt_widx;
  logic [3:0]     srt_wmon;
  logic [AW-1:0]  rec_raddr;
  rtms_pkg::rec_t rec_wdata;
  logic           out_free;

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= rtms_pkg::THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  // Input item register.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      inp <= in_rec;
      op  <= in_op;
    end
  end

  // Record memory, one write and one registered read per cycle.
  assign rec_raddr = cmd.rec_rd_srt ? srt_idx_rd : rec_rd_addr;
  assign rec_wdata = cmd.rec_wr_in ? inp : rec_rd;

  always_ff @(posedge clk) begin
    if (cmd.rec_wr) begin
      rec_mem[rec_wr_addr] <= rec_wdata;
    end
    if (cmd.rec_rd) begin
      rec_rd <= rec_mem[rec_raddr];
    end
  end

  // Sort order memory; a compare writes the held entry when it swaps.
  assign swap     = cur_mon > srt_mon_rd;
  assign srt_we   = cmd.srt_wr | (cmd.srt_cmp & swap);
  assign srt_widx = cmd.srt_wr_init ? srt_wr_addr : cur_idx;
  assign srt_wmon = cmd.srt_wr_init ? rec_rd.month : cur_mon;

  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_idx_mem[srt_wr_addr] <= srt_widx;
      srt_mon_mem[srt_wr_addr] <= srt_wmon;
    end
    if (cmd.srt_rd) begin
      srt_idx_rd <= srt_idx_mem[srt_rd_addr];
      srt_mon_rd <= srt_mon_mem[srt_rd_addr];
    end
  end

  // Held entry of the outer sort position.
  always_ff @(posedge clk) begin
    if (cmd.cur_load || (cmd.srt_cmp && swap)) begin
      cur_idx <= srt_idx_rd;
      cur_mon <= srt_mon_rd;
    end
  end

  // Count of quantities above the threshold.
  always_ff @(posedge clk) begin
    if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_acc && ($signed(rec_rd.qty) > $signed(thr))) begin
      cnt <= cnt + CntW'(1);
    end
  end

  // Result register; it frees up in the cycle its beat is taken.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_src)
        rtms_pkg::SRC_FULL: begin
          out_status <= rtms_pkg::ST_FULL;
          out_rec    <= '0;
          out_cnt    <= '0;
          out_last   <= 1'b1;
        end
        rtms_pkg::SRC_ECHO: begin
          out_status <= rtms_pkg::ST_OK;
          out_rec    <= inp;
          out_cnt    <= '0;
          out_last   <= 1'b1;
        end
        rtms_pkg::SRC_REC: begin
          out_status <= rtms_pkg::ST_OK;
          out_rec    <= rec_rd;
          out_cnt    <= '0;
          out_last   <= cmd.out_last;
        end
        rtms_pkg::SRC_COUNT: begin
          out_status <= rtms_pkg::ST_OK;
          out_rec    <= '0;
          out_cnt    <= cnt;
          out_last   <= 1'b1;
        end
        default: begin
          out_status <= rtms_pkg::ST_EMPTY;
          out_rec    <= '0;
          out_cnt    <= '0;
          out_last   <= 1'b1;
        end
      endcase
    end
  end

  // Status back to the controller.
  assign sts.out_free   = out_free;
  assign sts.code_match = rec_rd.code == inp.code;
  assign sts.op         = op;

endmodule

// File: hdl/rtms_ctrl.sv
// ----------------------------------------------------------------------------
// rtms_ctrl: record table controller
// Sequences each operation over the memories and keeps the fill count and
// the scan indexes.
// ----------------------------------------------------------------------------
module rtms_ctrl #(
  parameter int TABLE_DEPTH = rtms_pkg::TABLE_DEPTH,
  localparam int AW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rtms_pkg::sts_t sts,
  output rtms_pkg::cmd_t cmd,
  output logic [AW-1:0]  rec_rd_addr,
  output logic [AW-1:0]  rec_wr_addr,
  output logic [AW-1:0]  srt_rd_addr,
  output logic [AW-1:0]  srt_wr_addr
);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_DISP     = 5'd1;
  localparam logic [4:0] S_DEL_RD   = 5'd2;
  localparam logic [4:0] S_DEL_CMP  = 5'd3;
  localparam logic [4:0] S_NFOUND   = 5'd4;
  localparam logic [4:0] S_SH_RD    = 5'd5;
  localparam logic [4:0] S_SH_WR    = 5'd6;
  localparam logic [4:0] S_CNT_RD   = 5'd7;
  localparam logic [4:0] S_CNT_ACC  = 5'd8;
  localparam logic [4:0] S_CNT_OUT  = 5'd9;
  localparam logic [4:0] S_LST_RD   = 5'd10;
  localparam logic [4:0] S_LST_EMIT = 5'd11;
  localparam logic [4:0] S_INI_RD   = 5'd12;
  localparam logic [4:0] S_INI_WR   = 5'd13;
  localparam logic [4:0] S_SRT_RDI  = 5'd14;
  localparam logic [4:0] S_SRT_LDI  = 5'd15;
  localparam logic [4:0] S_SRT_CMP  = 5'd16;
  localparam logic [4:0] S_SRT_END  = 5'd17;
  localparam logic [4:0] S_MEM_RDS  = 5'd18;
  localparam logic [4:0] S_MEM_RDR  = 5'd19;
  localparam logic [4:0] S_MEM_EMIT = 5'd20;

  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  logic [4:0]    state, state_next;
  logic [CW-1:0] n, n_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] i_inc, j_inc;

  assign i_inc    = i + CW'(1);
  assign j_inc    = j + CW'(1);
  assign in_ready = state == S_IDLE;

  // State and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
      i     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
      i     <= i_next;
      j     <= j_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    n_next      = n;
    i_next      = i;
    j_next      = j;
    cmd         = '0;
    rec_rd_addr = i[AW-1:0];
    rec_wr_addr = j[AW-1:0];
    srt_rd_addr = i[AW-1:0];
    srt_wr_addr = i[AW-1:0];
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.out_free) begin
          i_next     = '0;
          j_next     = '0;
          state_next = S_IDLE;
          case (sts.op)
            rtms_pkg::OP_APPEND: begin
              cmd.out_load = 1'b1;
              if (n == FULL) begin
                cmd.out_src = rtms_pkg::SRC_FULL;
              end else begin
                cmd.out_src   = rtms_pkg::SRC_ECHO;
                cmd.rec_wr    = 1'b1;
                cmd.rec_wr_in = 1'b1;
                rec_wr_addr   = n[AW-1:0];
                n_next        = n + CW'(1);
              end
            end
            rtms_pkg::OP_DELETE, rtms_pkg::OP_COUNT, rtms_pkg::OP_LIST,
            rtms_pkg::OP_MLIST: begin
              if (n == '0) begin
                cmd.out_load = 1'b1;
                cmd.out_src  = rtms_pkg::SRC_EMPTY;
              end else begin
                case (sts.op)
                  rtms_pkg::OP_DELETE: state_next = S_DEL_RD;
                  rtms_pkg::OP_COUNT: begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_CNT_RD;
                  end
                  rtms_pkg::OP_LIST: state_next = S_LST_RD;
                  default: state_next = S_INI_RD;
                endcase
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      // Delete: find the first matching code.
      S_DEL_RD: begin
        cmd.rec_rd = 1'b1;
        state_next = S_DEL_CMP;
      end
      S_DEL_CMP: begin
        if (sts.code_match) begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_src  = rtms_pkg::SRC_REC;
            cmd.out_last = 1'b1;
            j_next       = i;
            state_next   = S_SH_RD;
          end
        end else if (i_inc == n) begin
          state_next = S_NFOUND;
        end else begin
          i_next     = i_inc;
          state_next = S_DEL_RD;
        end
      end
      S_NFOUND: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = rtms_pkg::SRC_EMPTY;
          state_next   = S_IDLE;
        end
      end
      // Delete: move the tail down by one entry.
      S_SH_RD: begin
        if (j_inc >= n) begin
          n_next     = n - CW'(1);
          state_next = S_IDLE;
        end else begin
          cmd.rec_rd  = 1'b1;
          rec_rd_addr = j_inc[AW-1:0];
          state_next  = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.rec_wr = 1'b1;
        j_next     = j_inc;
        state_next = S_SH_RD;
      end
      // Count over threshold.
      S_CNT_RD: begin
        cmd.rec_rd = 1'b1;
        state_next = S_CNT_ACC;
      end
      S_CNT_ACC: begin
        cmd.cnt_acc = 1'b1;
        if (i_inc == n) begin
          state_next = S_CNT_OUT;
        end else begin
          i_next     = i_inc;
          state_next = S_CNT_RD;
        end
      end
      S_CNT_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = rtms_pkg::SRC_COUNT;
          state_next   = S_IDLE;
        end
      end
      // List in stored order.
      S_LST_RD: begin
        cmd.rec_rd = 1'b1;
        state_next = S_LST_EMIT;
      end
      S_LST_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = rtms_pkg::SRC_REC;
          cmd.out_last = i_inc == n;
          i_next       = i_inc;
          state_next   = (i_inc == n) ? S_IDLE : S_LST_RD;
        end
      end
      // Month list: load index and month of every entry.
      S_INI_RD: begin
        cmd.rec_rd = 1'b1;
        state_next = S_INI_WR;
      end
      S_INI_WR: begin
        cmd.srt_wr      = 1'b1;
        cmd.srt_wr_init = 1'b1;
        if (i_inc == n) begin
          i_next     = '0;
          state_next = S_SRT_RDI;
        end else begin
          i_next     = i_inc;
          state_next = S_INI_RD;
        end
      end
      // Exchange sort: hold entry i, compare against each later entry.
      S_SRT_RDI: begin
        cmd.srt_rd = 1'b1;
        state_next = S_SRT_LDI;
      end
      S_SRT_LDI: begin
        cmd.cur_load = 1'b1;
        if (i_inc < n) begin
          cmd.srt_rd  = 1'b1;
          srt_rd_addr = i_inc[AW-1:0];
          j_next      = i_inc;
          state_next  = S_SRT_CMP;
        end else begin
          state_next = S_SRT_END;
        end
      end
      S_SRT_CMP: begin
        cmd.srt_cmp = 1'b1;
        srt_wr_addr = j[AW-1:0];
        if (j_inc < n) begin
          cmd.srt_rd  = 1'b1;
          srt_rd_addr = j_inc[AW-1:0];
          j_next      = j_inc;
        end else begin
          state_next = S_SRT_END;
        end
      end
      S_SRT_END: begin
        cmd.srt_wr = 1'b1;
        if (i_inc >= n) begin
          i_next     = '0;
          state_next = S_MEM_RDS;
        end else begin
          i_next     = i_inc;
          state_next = S_SRT_RDI;
        end
      end
      // Month list: emit through the sort order.
      S_MEM_RDS: begin
        cmd.srt_rd = 1'b1;
        state_next = S_MEM_RDR;
      end
      S_MEM_RDR: begin
        cmd.rec_rd     = 1'b1;
        cmd.rec_rd_srt = 1'b1;
        state_next     = S_MEM_EMIT;
      end
      S_MEM_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_src  = rtms_pkg::SRC_REC;
          cmd.out_last = i_inc == n;
          i_next       = i_inc;
          state_next   = (i_inc == n) ? S_IDLE : S_MEM_RDS;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // The fill count never passes the table size.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst) n <= FULL)
    else $error("fill count beyond table size");

  // A result is only loaded while the result register can take it.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over a pending beat");

  // An append into a table with room grows the fill count by one.
  a_append_grow: assert property (@(posedge clk) disable iff (rst)
    (state == S_DISP && sts.out_free && sts.op == rtms_pkg::OP_APPEND && n != FULL)
    |=> n == $past(n) + CW'(1))
    else $error("append did not grow the table");

  // Scan indexes stay inside the table while it is in use.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_DISP && n != '0) |-> (i < n && j < n))
    else $error("scan index beyond fill count");

endmodule

// File: hdl/record_table_with_month_sort_core.sv
// ----------------------------------------------------------------------------
// record_table_with_month_sort_core: ordered record table with month list
// Append, delete by code, count over threshold, list, and list by month.
//
//   channel  dir  handshake          contents
//   cfg      in   cfg_wr_en          cfg_wr_data = quantity threshold
//   s        in   s_tvalid/s_tready  s_tuser = opcode, s_tdata = record
//   m        out  m_tvalid/m_tready  m_tuser = status, m_tdata, m_tlast
//
// One item at a time; s_tready is high only while the controller idles.
// Delete scans the entries for the code, then moves each later entry down
// (one memory port each way). Month list time is set by one compare a cycle
// in the exchange sort.
// Reset is synchronous and empties the table; memories are not cleared.
// A stalled output holds the controller in its emit state until taken.
// ----------------------------------------------------------------------------
module record_table_with_month_sort_core #(
  parameter int TABLE_DEPTH = rtms_pkg::TABLE_DEPTH,
  localparam int AW   = $clog2(TABLE_DEPTH),
  localparam int CntW = $clog2(TABLE_DEPTH + 1),
  localparam int OutW = ((rtms_pkg::REC_W + CntW + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [31:0]               cfg_wr_data,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // code, quantity, price bits, day, month
  input  logic [rtms_pkg::IN_W-1:0] s_tdata,
  // opcode
  input  logic [2:0]                s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // out_code, out_quantity, out_price_bits, out_day, out_month, over_count
  output logic [OutW-1:0]           m_tdata,
  // status
  output logic [1:0]                m_tuser,
  output logic                      m_tlast
);

  rtms_pkg::cmd_t cmd;
  rtms_pkg::sts_t sts;
  rtms_pkg::rec_t out_rec;
  logic [CntW-1:0] out_cnt;
  logic [AW-1:0]  rec_rd_addr, rec_wr_addr, srt_rd_addr, srt_wr_addr;

  rtms_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .sts         (sts),
    .cmd         (cmd),
    .rec_rd_addr (rec_rd_addr),
    .rec_wr_addr (rec_wr_addr),
    .srt_rd_addr (srt_rd_addr),
    .srt_wr_addr (srt_wr_addr)
  );

  rtms_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_rec      (rtms_pkg::rec_t'(s_tdata[rtms_pkg::REC_W-1:0])),
    .in_op       (s_tuser),
    .cmd         (cmd),
    .rec_rd_addr (rec_rd_addr),
    .rec_wr_addr (rec_wr_addr),
    .srt_rd_addr (srt_rd_addr),
    .srt_wr_addr (srt_wr_addr),
    .sts         (sts),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (m_tuser),
    .out_rec     (out_rec),
    .out_cnt     (out_cnt),
    .out_last    (m_tlast)
  );

  // Result beat packing, zero filled to whole bytes.
  assign m_tdata = OutW'({out_cnt, out_rec});

endmodule
